// ===== sv/wbps_pkg.sv =====
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int ULEN_W          = 8;
  localparam int ENTRY_W         = 6;
  localparam int BYTE_W          = 8;
  localparam int CFG_W           = 7;
  localparam int POS_W           = 32;

  localparam logic             CMD_LOAD = 1'b0;
  localparam logic             CMD_BYTE = 1'b1;
  localparam logic [BYTE_W-1:0] WILDCARD = 8'h3F;
  localparam logic [POS_W-1:0]  POS_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               command;
    logic [ENTRY_W-1:0] entry_index;
    logic [BYTE_W-1:0]  byte_value;
    logic               last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_offset;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic clear;
    logic hold;
  } cell_ctrl_t;

endpackage

// ===== sv/wbps_cell.sv =====
`timescale 1ns / 1ps

module wbps_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wbps_pkg::cell_ctrl_t       ctrl,
  input  logic [wbps_pkg::BYTE_W-1:0] src_byte,
  input  logic                       load_en,
  input  logic                       active,
  input  logic                       is_last,
  input  logic                       prev_bit,
  output logic                       bit_q,
  output logic                       tap
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] pat_r;
  logic [BYTE_W-1:0] pat_nxt;
  logic              prog_r;
  logic              prog_nxt;
  logic              hit;
  logic              bit_new;

  assign hit     = (pat_r == WILDCARD) || (pat_r == src_byte);
  assign bit_new = active && prev_bit && hit;
  assign tap     = bit_new && is_last;
  assign bit_q   = prog_r;
  assign pat_nxt = load_en ? src_byte : pat_r;

  always_comb begin
    prog_nxt = prog_r;
    if (ctrl.step) begin
      if (ctrl.clear) begin
        prog_nxt = 1'b0;
      end else if (!ctrl.hold) begin
        prog_nxt = bit_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= 1'b0;
    end else begin
      prog_r <= prog_nxt;
    end
  end

endmodule

// ===== sv/wildcard_byte_pattern_search_unit.sv =====
`timescale 1ns / 1ps
// A result appears in the output register in the cycle after its last byte is taken.
// One item per cycle unless stalled; the comparison chain checks every entry each cycle.
// Input is taken whenever the output register is empty or being drained in the same cycle.
// Reset (rst_n, synchronous, active low) clears progress bits, position and match state,
// and sets the pattern length to one; pattern entries are undefined until loaded.

module wildcard_byte_pattern_search_unit #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wbps_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wbps_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wbps_pkg::CFG_W-1:0]  cfg_data
);
  import wbps_pkg::*;

  logic [CFG_W-1:0]       len_r;
  logic [ULEN_W-1:0]      ulen;
  logic                   accept;
  logic                   is_load;
  logic                   is_step;
  logic                   is_last;
  cell_ctrl_t             ctrl;
  logic [MAX_PATTERN-1:0] bits;
  logic [MAX_PATTERN-1:0] taps;
  logic                   tap_any;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  logic [POS_W-1:0] first_r, first_nxt;
  logic             seen_new;
  logic [POS_W-1:0] first_new;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;
  assign ulen = ({1'b0, len_r} > ULEN_W'(MAX_PATTERN)) ? ULEN_W'(MAX_PATTERN) : {1'b0, len_r};

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && (in_data.command == CMD_LOAD);
  assign is_step  = accept && (in_data.command == CMD_BYTE);
  assign is_last  = is_step && in_data.last_of_buffer;

  assign ctrl.step  = is_step;
  assign ctrl.clear = in_data.last_of_buffer;
  assign ctrl.hold  = (ulen == '0);

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = bits[k-1];
    end
    wbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .src_byte (in_data.byte_value),
      .load_en  (is_load && (k < (1 << ENTRY_W)) && (in_data.entry_index == ENTRY_W'(k))),
      .active   (ulen > ULEN_W'(k)),
      .is_last  (ulen == ULEN_W'(k + 1)),
      .prev_bit (prev),
      .bit_q    (bits[k]),
      .tap      (taps[k])
    );
  end

  assign tap_any = |taps;

  always_comb begin
    seen_new  = seen_r;
    first_new = first_r;
    if (!seen_r) begin
      if (ctrl.hold) begin
        seen_new  = 1'b1;
        first_new = '0;
      end else if (tap_any) begin
        seen_new  = 1'b1;
        first_new = pos_r - (POS_W'(ulen) - POS_W'(1));
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    if (is_step) begin
      if (in_data.last_of_buffer) begin
        pos_nxt   = '0;
        seen_nxt  = 1'b0;
        first_nxt = '0;
      end else begin
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
        seen_nxt  = seen_new;
        first_nxt = first_new;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (is_last) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.found        = seen_new;
      out_data_nxt.match_offset = seen_new ? first_new : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= CFG_W'(1);
      pos_r       <= '0;
      seen_r      <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_data;
      end
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_last |=> out_valid)
    else $error("last byte transfer did not produce a result");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.match_offset == '0))
    else $error("offset is not zero for a result without a match");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_last |=> (pos_r == '0) && !seen_r && (first_r == '0))
    else $error("search state not cleared after the last byte");

endmodule
